[hw/rtl/mclk_pkg.sv]
// Package for the Morse code lamp keyer.
// Holds the word types, phase codes, register indexes and the character table.
// No dependencies.
package mclk_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_OFF  = 3'd4;

    // Register values after reset.
    localparam logic [TICK_W-1:0] RST_DOT_ON   = 16'd150;
    localparam logic [TICK_W-1:0] RST_DASH_ON  = 16'd350;
    localparam logic [TICK_W-1:0] RST_ELEM_GAP = 16'd150;
    localparam logic [TICK_W-1:0] RST_SEP_ON   = 16'd250;
    localparam logic [TICK_W-1:0] RST_SEP_OFF  = 16'd150;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
    } t_item;

    typedef struct packed {
        logic dot_lamp;
        logic dash_lamp;
        logic sep_lamp;
        logic busy_res;
        logic accepted;
    } t_res;

    // Classified input word: character flag, element count, dash mask (LSB first).
    typedef struct packed {
        logic       is_char;
        logic [2:0] len;
        logic [4:0] bits;
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ELEM_ON,
        PH_ELEM_OFF,
        PH_SEP_ON,
        PH_SEP_OFF
    } t_phase;

    // Returns {length, pattern}; zero for anything that is not a letter or digit.
    function automatic logic [7:0] morse_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] code;
        u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
        case (u)
            8'h41: code = {3'd2, 5'd2};
            8'h42: code = {3'd4, 5'd1};
            8'h43: code = {3'd4, 5'd5};
            8'h44: code = {3'd3, 5'd1};
            8'h45: code = {3'd1, 5'd0};
            8'h46: code = {3'd4, 5'd4};
            8'h47: code = {3'd3, 5'd3};
            8'h48: code = {3'd4, 5'd0};
            8'h49: code = {3'd2, 5'd0};
            8'h4A: code = {3'd4, 5'd14};
            8'h4B: code = {3'd3, 5'd5};
            8'h4C: code = {3'd4, 5'd2};
            8'h4D: code = {3'd2, 5'd3};
            8'h4E: code = {3'd2, 5'd1};
            8'h4F: code = {3'd3, 5'd7};
            8'h50: code = {3'd4, 5'd6};
            8'h51: code = {3'd4, 5'd11};
            8'h52: code = {3'd3, 5'd2};
            8'h53: code = {3'd3, 5'd0};
            8'h54: code = {3'd1, 5'd1};
            8'h55: code = {3'd3, 5'd4};
            8'h56: code = {3'd4, 5'd8};
            8'h57: code = {3'd3, 5'd6};
            8'h58: code = {3'd4, 5'd9};
            8'h59: code = {3'd4, 5'd13};
            8'h5A: code = {3'd4, 5'd3};
            8'h30: code = {3'd5, 5'd31};
            8'h31: code = {3'd5, 5'd30};
            8'h32: code = {3'd5, 5'd28};
            8'h33: code = {3'd5, 5'd24};
            8'h34: code = {3'd5, 5'd16};
            8'h35: code = {3'd5, 5'd0};
            8'h36: code = {3'd5, 5'd1};
            8'h37: code = {3'd5, 5'd3};
            8'h38: code = {3'd5, 5'd7};
            8'h39: code = {3'd5, 5'd15};
            default: code = 8'd0;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/mclk_fifo.sv]
// Small register queue used between the keyer stages and on the result side.
// Generic width and depth; no package dependency.
module mclk_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

[hw/rtl/mclk_front.sv]
// Front stage of the keyer: takes input words and classifies them.
// Uses mclk_pkg for the word types and the character table.
module mclk_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mclk_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_ready,
    output logic           o_valid,
    output mclk_pkg::t_cls o_cls
);
    import mclk_pkg::*;

    logic       r_valid, n_valid;
    t_cls       r_cls;
    logic       take;
    logic [7:0] code;

    assign o_full  = r_valid && !i_ready;
    assign take    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign code    = morse_lookup(i_item.char_code);

    always_comb begin
        n_valid = take || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls.is_char <= i_item.cmd;
            r_cls.len     <= code[7:5];
            r_cls.bits    <= code[4:0];
        end
    end
endmodule

[hw/rtl/mclk_back.sv]
// Back stage of the keyer: phase machine, tick counter and timing registers.
// Uses mclk_pkg for the phase codes, register indexes and word types.
module mclk_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mclk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mclk_pkg::TICK_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    input  mclk_pkg::t_cls                    i_cls,
    output logic                              o_pop,
    input  logic                              i_out_full,
    output logic                              o_push,
    output mclk_pkg::t_res                    o_res
);
    import mclk_pkg::*;

    logic [TICK_W-1:0] r_dot_on, r_dash_on, r_elem_gap, r_sep_on, r_sep_off;

    t_phase            r_phase, n_phase;
    logic [4:0]        r_bits, n_bits;
    logic [2:0]        r_len, n_len;
    logic [2:0]        r_idx, n_idx;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic              fire;
    logic              idle;
    logic              on;
    logic              dash_now;
    logic              took;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // Element positions past the stored mask read as dots.
    function automatic logic dash_at(input logic [4:0] bits, input logic [2:0] idx);
        logic [7:0] wide;
        wide = {3'b000, bits};
        return wide[idx];
    endfunction

    assign fire   = i_valid && !i_out_full;
    assign o_pop  = fire;
    assign o_push = fire;
    assign idle   = (r_phase == PH_IDLE);

    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_len   = r_len;
        n_idx   = r_idx;
        n_ticks = r_ticks;
        took    = 1'b0;
        if (i_cls.is_char) begin
            if (idle) begin
                took   = 1'b1;
                n_bits = i_cls.bits;
                n_len  = i_cls.len;
                n_idx  = 3'd0;
                if (i_cls.len != 3'd0) begin
                    n_phase = PH_ELEM_ON;
                    n_ticks = at_least_one(i_cls.bits[0] ? r_dash_on : r_dot_on);
                end else begin
                    n_phase = PH_SEP_ON;
                    n_ticks = at_least_one(r_sep_on);
                end
            end
        end else if (!idle) begin
            if (r_ticks > TICK_W'(1)) begin
                n_ticks = r_ticks - 1'b1;
            end else begin
                unique case (r_phase)
                    PH_ELEM_ON: begin
                        n_phase = PH_ELEM_OFF;
                        n_ticks = at_least_one(r_elem_gap);
                    end
                    PH_ELEM_OFF: begin
                        n_idx = r_idx + 1'b1;
                        if (n_idx < r_len) begin
                            n_phase = PH_ELEM_ON;
                            n_ticks = at_least_one(dash_at(r_bits, n_idx) ? r_dash_on
                                                                          : r_dot_on);
                        end else begin
                            n_phase = PH_SEP_ON;
                            n_ticks = at_least_one(r_sep_on);
                        end
                    end
                    PH_SEP_ON: begin
                        n_phase = PH_SEP_OFF;
                        n_ticks = at_least_one(r_sep_off);
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_ticks = '0;
                    end
                endcase
            end
        end

        // The result shows the levels after this word's update.
        on              = (n_phase == PH_ELEM_ON);
        dash_now        = dash_at(n_bits, n_idx);
        o_res.dot_lamp  = on && !dash_now;
        o_res.dash_lamp = on && dash_now;
        o_res.sep_lamp  = (n_phase == PH_SEP_ON);
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.accepted  = took;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_ticks <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_on   <= RST_DOT_ON;
            r_dash_on  <= RST_DASH_ON;
            r_elem_gap <= RST_ELEM_GAP;
            r_sep_on   <= RST_SEP_ON;
            r_sep_off  <= RST_SEP_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOT_ON:   r_dot_on   <= i_cfg_data;
                CFG_DASH_ON:  r_dash_on  <= i_cfg_data;
                CFG_ELEM_GAP: r_elem_gap <= i_cfg_data;
                CFG_SEP_ON:   r_sep_on   <= i_cfg_data;
                CFG_SEP_OFF:  r_sep_off  <= i_cfg_data;
                default: ;
            endcase
        end
    end
endmodule

[hw/rtl/morse_code_lamp_keyer_top.sv]
// Top level of the Morse code lamp keyer.
// Instantiates mclk_front, mclk_fifo and mclk_back; uses mclk_pkg.
// Usage:
//   Input channel (push/full) carries one word per tick or character:
//   cmd 0 is a one-millisecond tick, cmd 1 asks to key char_code.
//   Result channel (empty/pop) returns exactly one word per input word with
//   the three lamp levels, the busy flag and whether a character was taken.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   index 0 dot on, 1 dash on, 2 element gap, 3 separator on,
//   4 separator off, all in ticks; other indexes are ignored.
// Throughput: one word per cycle sustained while results are popped and nothing
//   stalls. Each word passes through the classify register and is then carried
//   out by the phase machine from the middle queue.
// Path: a taken word is registered in the classify register, then in the
//   middle queue, then its result in the result queue, where it can be popped.
// Reset: synchronous, active low; all queues empty, phase idle, timing
//   registers back to their defaults. full and empty are valid right after.
// Stall: when pop stays low, results collect in the result queue, then the
//   phase machine holds, then the middle queue fills and finally full rises.
//   No word is dropped at the ports.
module morse_code_lamp_keyer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  mclk_pkg::t_item                i_item,
    output logic                           full,
    input  logic                           pop,
    output logic                           empty,
    output mclk_pkg::t_res                 o_res,
    input  logic                           i_cfg_we,
    input  logic [mclk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mclk_pkg::TICK_W-1:0]    i_cfg_data
);
    import mclk_pkg::*;

    logic  front_valid;
    t_cls  front_cls;
    logic  mid_full, mid_empty;
    logic  [$bits(t_cls)-1:0] mid_data;
    t_cls  mid_cls;
    logic  back_pop, back_push;
    t_res  back_res;
    logic  out_full;
    logic  [$bits(t_res)-1:0] out_data;

    mclk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_ready (!mid_full),
        .o_valid (front_valid),
        .o_cls   (front_cls)
    );

    mclk_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cls),
        .o_full  (mid_full),
        .i_pop   (back_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign mid_cls = t_cls'(mid_data);

    mclk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (!mid_empty),
        .i_cls      (mid_cls),
        .o_pop      (back_pop),
        .i_out_full (out_full),
        .o_push     (back_push),
        .o_res      (back_res)
    );

    mclk_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_res = t_res'(out_data);
endmodule

[hw/rtl/mclk_checker.sv]
// Port-level checks for the Morse code lamp keyer, bound to the top level.
// Uses mclk_pkg for the result word type.
module mclk_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           pop,
    input logic           empty,
    input mclk_pkg::t_res i_res
);
    import mclk_pkg::*;

    // After a reset edge the result queue is empty and the input is not full.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result word holds until it is popped.
    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(i_res)))
        else $error("stalled result word changed");

    // At most one lamp is lit in any result word.
    a_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> $onehot0({i_res.dot_lamp, i_res.dash_lamp, i_res.sep_lamp}))
        else $error("more than one lamp lit");

    // A lit lamp or a taken character means the keyer is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (i_res.dot_lamp || i_res.dash_lamp || i_res.sep_lamp ||
                    i_res.accepted)) |-> i_res.busy_res)
        else $error("lamp lit or character taken while not busy");
endmodule

bind morse_code_lamp_keyer_top mclk_checker u_mclk_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .i_res   (o_res)
);
